// File: src/cbk_pkg.sv
`default_nettype none

package cbk_pkg;

    // Fixed field formats
    localparam int OFFSET_W  = 16;   // input offset, signed
    localparam int MAG_W     = 17;   // |offset|, 0..32768
    localparam int OUT_W     = 16;   // each result field, signed Q2.14
    localparam int OUT_FRAC  = 14;
    localparam int PRE_W     = 17;   // 6*weight before the divide, 0..65536
    localparam int SMAG_W    = 15;   // slope magnitude, 0..10922

    // Divide by 3 through a reciprocal: floor(x/3) = (x * 43691) >> 17 for x < 2^16
    localparam int             RECIP3_W  = 17;
    localparam logic [16:0]    RECIP3    = 17'd43691;
    localparam int             RECIP3_SH = 17;

    // Per-item control carried alongside the data
    typedef struct packed {
        logic neg;     // offset was negative
        logic inner;   // |offset| < 1, inner cubic piece
    } cbk_ctl_t;

endpackage

`default_nettype wire

// File: src/cbk_fold.sv
`default_nettype none

// Stage 1: fold the offset to a magnitude and pick the spline piece.
// u is |x| on the inner piece and 2-|x| on the outer piece; outside
// the support u is zero, which makes all outer formulas give zero.
module cbk_fold
    import cbk_pkg::*;
#(
    parameter int IN_FRAC_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [OFFSET_W-1:0]   offset,
    output logic      [IN_FRAC_BITS:0] u,
    output cbk_ctl_t                   ctl
);

    localparam int UW = IN_FRAC_BITS + 1;
    localparam logic [MAG_W-1:0] ONE_S = MAG_W'(1) << IN_FRAC_BITS;
    localparam logic [MAG_W-1:0] TWO_S = MAG_W'(2) << IN_FRAC_BITS;

    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             is_inner;
    logic             is_outer;
    logic [MAG_W-1:0] k;
    logic [UW-1:0]    u_next;
    cbk_ctl_t         ctl_next;
    logic [UW-1:0]    u_reg;
    cbk_ctl_t         ctl_reg;

    // Magnitude held unsigned so the most negative offset folds to 2^15
    always_comb
    begin
        neg      = offset[OFFSET_W-1];
        mag      = neg ? (MAG_W'(17'h10000) - MAG_W'(offset)) : MAG_W'(offset);
        is_inner = (mag < ONE_S);
        is_outer = (mag < TWO_S);
        k        = TWO_S - mag;
        if (is_inner)
            u_next = UW'(mag);
        else if (is_outer)
            u_next = UW'(k);
        else
            u_next = '0;
        ctl_next.neg   = neg;
        ctl_next.inner = is_inner;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg   <= u_next;
            ctl_reg <= ctl_next;
        end
    end

    assign u   = u_reg;
    assign ctl = ctl_reg;

endmodule

`default_nettype wire

// File: src/cbk_poly.sv
`default_nettype none

// Stages 2 to 4: square, cube and combine the polynomial terms.
// Stage 2: u^2, slope product, curvature.
// Stage 3: u^3, slope magnitude.
// Stage 4: 6*B*S^3 numerator scaled to Q2.14 (divide by 6 follows), signed slope.
module cbk_poly
    import cbk_pkg::*;
#(
    parameter int IN_FRAC_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic [2:0]            en,
    input  wire logic [IN_FRAC_BITS:0] u,
    input  wire cbk_ctl_t              ctl,
    output logic      [PRE_W-1:0]      pre,
    output logic      [OUT_W-1:0]      slope,
    output logic      [OUT_W-1:0]      curvature
);

    localparam int F     = IN_FRAC_BITS;
    localparam int UW    = F + 1;
    localparam int SQW   = 2 * F + 2;
    localparam int TW    = F + 3;
    localparam int PW    = 2 * F + 4;
    localparam int CUW   = 3 * F + 3;
    localparam int NW    = 3 * F + 4;
    localparam int SL_SH = 2 * F + 1 - OUT_FRAC;
    localparam int W_SH  = 3 * F - OUT_FRAC;
    localparam int C_SH  = OUT_FRAC - F;

    localparam logic [TW-1:0] TWO_S   = TW'(2) << F;
    localparam logic [TW-1:0] FOUR_S  = TW'(4) << F;
    localparam logic [NW-1:0] FOUR_S3 = NW'(1) << (3 * F + 2);

    // Stage 2 signals
    logic [TW-1:0]  u3;
    logic [TW-1:0]  t4;
    logic [TW-1:0]  c_raw;
    logic [16:0]    c_sh;
    logic [SQW-1:0] sq2_next;
    logic [PW-1:0]  prod2_next;
    logic [SQW-1:0] sq2_reg;
    logic [PW-1:0]  prod2_reg;
    logic [UW-1:0]  u2_reg;
    cbk_ctl_t       ctl2_reg;
    logic [OUT_W-1:0] curv2_reg;

    // Stage 3 signals
    logic [CUW-1:0]    cube3_next;
    logic [PW-1:0]     ssel;
    logic [PW-1:0]     ssh;
    logic [SMAG_W-1:0] smag3_next;
    logic [CUW-1:0]    cube3_reg;
    logic [SQW-1:0]    sq3_reg;
    logic [SMAG_W-1:0] smag3_reg;
    cbk_ctl_t          ctl3_reg;
    logic [OUT_W-1:0]  curv3_reg;

    // Stage 4 signals
    logic [NW-1:0]    three_cube;
    logic [NW-1:0]    six_sqs;
    logic [NW-1:0]    num;
    logic [NW-1:0]    num_sh;
    logic [OUT_W-1:0] smag_ext;
    logic [OUT_W-1:0] slope4_next;
    logic [PRE_W-1:0] pre4_reg;
    logic [OUT_W-1:0] slope4_reg;
    logic [OUT_W-1:0] curv4_reg;

    // Stage 2: square, slope product a*(4S-3a), curvature (3a-2S or 2-a)
    always_comb
    begin
        u3         = TW'(u) + (TW'(u) << 1);
        t4         = FOUR_S - u3;
        sq2_next   = SQW'(u) * SQW'(u);
        prod2_next = PW'(u) * PW'(t4);
        c_raw      = ctl.inner ? (u3 - TWO_S) : TW'(u);
        c_sh       = 17'($signed(c_raw)) <<< C_SH;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq2_reg   <= sq2_next;
            prod2_reg <= prod2_next;
            u2_reg    <= u;
            ctl2_reg  <= ctl;
            curv2_reg <= c_sh[OUT_W-1:0];
        end
    end

    // Stage 3: cube and slope magnitude
    always_comb
    begin
        cube3_next = CUW'(sq2_reg) * CUW'(u2_reg);
        ssel       = ctl2_reg.inner ? prod2_reg : PW'(sq2_reg);
        ssh        = ssel >> SL_SH;
        smag3_next = ssh[SMAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cube3_reg <= cube3_next;
            sq3_reg   <= sq2_reg;
            smag3_reg <= smag3_next;
            ctl3_reg  <= ctl2_reg;
            curv3_reg <= curv2_reg;
        end
    end

    // Stage 4: inner numerator 4S^3 + 3a^3 - 6a^2 S, outer (2-a)^3, scaled to Q2.14
    always_comb
    begin
        three_cube  = (NW'(cube3_reg) << 1) + NW'(cube3_reg);
        six_sqs     = (NW'(sq3_reg) << (F + 2)) + (NW'(sq3_reg) << (F + 1));
        num         = ctl3_reg.inner ? (FOUR_S3 + three_cube - six_sqs) : NW'(cube3_reg);
        num_sh      = num >> W_SH;
        smag_ext    = OUT_W'(smag3_reg);
        slope4_next = ctl3_reg.neg ? smag_ext : (OUT_W'(0) - smag_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pre4_reg   <= num_sh[PRE_W-1:0];
            slope4_reg <= slope4_next;
            curv4_reg  <= curv3_reg;
        end
    end

    assign pre       = pre4_reg;
    assign slope     = slope4_reg;
    assign curvature = curv4_reg;

endmodule

`default_nettype wire

// File: src/cbk_div6.sv
`default_nettype none

// Stage 5: weight = floor(pre / 6) = floor(floor(pre / 2) / 3), by reciprocal.
// This is also the output register.
module cbk_div6
    import cbk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [PRE_W-1:0]  pre,
    input  wire logic [OUT_W-1:0]  slope_in,
    input  wire logic [OUT_W-1:0]  curv_in,
    output logic      [OUT_W-1:0]  weight,
    output logic      [OUT_W-1:0]  slope,
    output logic      [OUT_W-1:0]  curvature
);

    localparam int MW = OUT_W + RECIP3_W;

    logic [OUT_W-1:0] half;
    logic [MW-1:0]    prod;
    logic [MW-1:0]    quo;
    logic [OUT_W-1:0] weight_reg;
    logic [OUT_W-1:0] slope_reg;
    logic [OUT_W-1:0] curv_reg;

    always_comb
    begin
        half = pre[PRE_W-1:1];
        prod = MW'(half) * MW'(RECIP3);
        quo  = prod >> RECIP3_SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= quo[OUT_W-1:0];
            slope_reg  <= slope_in;
            curv_reg   <= curv_in;
        end
    end

    assign weight    = weight_reg;
    assign slope     = slope_reg;
    assign curvature = curv_reg;

endmodule

`default_nettype wire

// File: src/cubic_bspline_kernel_eval.sv
`default_nettype none

// Cubic B-spline Parzen kernel evaluator. Each transaction on the s_ side
// carries one signed offset (IN_FRAC_BITS fraction bits); each transaction on
// the m_ side returns the kernel weight, its first derivative and its second
// derivative, all signed Q2.14 truncated toward zero, zero outside (-2, 2).
// The block is a five-stage pipeline (fold, square, cube, combine, divide by
// six) and accepts one offset every cycle while s_tready is high; m_tvalid
// is the valid bit of the last stage, whose register holds the result. Each
// stage holds its item while the next stage is full and cannot move on, so
// backpressure on m_tready stalls only as far back as needed and bubbles
// are squeezed out.
module cubic_bspline_kernel_eval
    import cbk_pkg::*;
#(
    parameter int IN_FRAC_BITS = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] offset
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [15:0] weight, [31:16] slope, [47:32] curvature
);

    localparam int NSTG = 5;

    logic [NSTG-1:0]     valid_reg;
    logic [NSTG-1:0]     valid_next;
    logic [NSTG-1:0]     adv;

    logic [IN_FRAC_BITS:0] u1;
    cbk_ctl_t              ctl1;
    logic [PRE_W-1:0]      pre4;
    logic [OUT_W-1:0]      slope4;
    logic [OUT_W-1:0]      curv4;
    logic [OUT_W-1:0]      weight_o;
    logic [OUT_W-1:0]      slope_o;
    logic [OUT_W-1:0]      curv_o;

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NSTG; i++)
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    cbk_fold #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_fold (
        .clk    (clk),
        .en     (adv[0]),
        .offset (s_tdata),
        .u      (u1),
        .ctl    (ctl1)
    );

    cbk_poly #(
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_poly (
        .clk       (clk),
        .en        (adv[3:1]),
        .u         (u1),
        .ctl       (ctl1),
        .pre       (pre4),
        .slope     (slope4),
        .curvature (curv4)
    );

    cbk_div6 u_div6 (
        .clk       (clk),
        .en        (adv[4]),
        .pre       (pre4),
        .slope_in  (slope4),
        .curv_in   (curv4),
        .weight    (weight_o),
        .slope     (slope_o),
        .curvature (curv_o)
    );

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = {curv_o, slope_o, weight_o};

endmodule

`default_nettype wire
